FILE: hdl/rad_pkg.sv
`default_nettype none

package rad_pkg;

    typedef enum logic [1:0] {
        ACT_LOAD_ENTRY = 2'd0,
        ACT_LOAD_STATE = 2'd1,
        ACT_DECODE     = 2'd2
    } t_action;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  context_req;
        logic [7:0]  entry_index;
        logic [4:0]  cutoff;
        logic [7:0]  right_symbol;
        logic [11:0] right_offset_base;
        logic [12:0] left_freq;
        logic [12:0] freq_xor;
        logic [31:0] stream_bits;
    } t_in_req;

    typedef struct packed {
        logic [7:0] symbol;
        logic [5:0] bits_consumed;
    } t_out_res;

    typedef struct packed {
        logic [4:0]  cutoff;
        logic [7:0]  right_symbol;
        logic [11:0] right_offset_base;
        logic [12:0] left_freq;
        logic [12:0] freq_xor;
    } t_entry;

    typedef struct packed {
        logic        state_we;
        logic [31:0] state;
        t_out_res    res;
    } t_step;

    localparam logic [31:0] REFILL_LIMIT = 32'h0001_0000;
    localparam logic [5:0]  USED_NONE    = 6'd0;
    localparam logic [5:0]  USED_HALF    = 6'd16;
    localparam logic [5:0]  USED_FULL    = 6'd32;

endpackage

`default_nettype wire

FILE: hdl/rans_alias_symbol_decoder.sv
`default_nettype none

// Channel   Direction  Handshake                  Payload
// request   in         i_in_valid / o_in_ready    i_in  (t_in_req)
// result    out        o_out_valid / i_out_ready  o_out (t_out_res)
//
// Loads and skipped requests flow at one per cycle while the result side
// is ready; a decode or state load blocks the next decode until it leaves
// stage 1, so decodes do not overlap: table read, then multiply, refill
// and state register. Reset clears the coder state and valid flags; the
// alias table holds garbage until written. A stalled result holds the
// pipe while the request side keeps one item in flight.

module rans_alias_symbol_decoder
    import rad_pkg::*;
#(
    parameter int ANS_BITS       = 12,
    parameter int LOG_ENTRY_SIZE = 4,
    parameter int CONTEXTS       = 8
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in_req i_in,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out_res  o_out
);

    localparam int          ENTRY_LOG = ANS_BITS - LOG_ENTRY_SIZE;
    localparam int          MEM_DEPTH = CONTEXTS << ENTRY_LOG;
    localparam int          ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam logic [31:0] IDX_MASK  = (32'd1 << ENTRY_LOG) - 32'd1;
    localparam logic [31:0] CTX_LIMIT = CONTEXTS;

    t_entry              r_mem [MEM_DEPTH];
    t_entry              r_rd_data;
    logic [31:0]         r_state;
    logic                r_s1_valid;
    logic [1:0]          r_s1_action;
    logic                r_s1_ok;
    logic [31:0]         r_s1_window;
    logic                r_out_valid;
    t_out_res            r_out;

    logic                in_accept;
    logic                s1_adv;
    logic                state_busy;
    logic                ctx_ok;
    logic                mem_we;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   rd_addr;
    t_entry              wr_data;
    t_step               step;

    always_comb begin
        ctx_ok     = 32'(i_in.context_req) < CTX_LIMIT;
        s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
        state_busy = r_s1_valid &&
                     (r_s1_action == ACT_DECODE || r_s1_action == ACT_LOAD_STATE);
        o_in_ready = (!r_s1_valid || s1_adv) &&
                     !(i_in.action == ACT_DECODE && state_busy);
        in_accept  = i_in_valid && o_in_ready;
        mem_we     = in_accept && ctx_ok && i_in.action == ACT_LOAD_ENTRY;
        wr_addr    = ADDR_W'((32'(i_in.context_req) << ENTRY_LOG) +
                             (32'(i_in.entry_index) & IDX_MASK));
        rd_addr    = ADDR_W'((32'(i_in.context_req) << ENTRY_LOG) +
                             ((r_state >> LOG_ENTRY_SIZE) & IDX_MASK));
        wr_data    = t_entry'{
            cutoff:            i_in.cutoff,
            right_symbol:      i_in.right_symbol,
            right_offset_base: i_in.right_offset_base,
            left_freq:         i_in.left_freq,
            freq_xor:          i_in.freq_xor
        };
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (in_accept) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    rad_step #(
        .ANS_BITS       (ANS_BITS),
        .LOG_ENTRY_SIZE (LOG_ENTRY_SIZE)
    ) u_step (
        .i_state  (r_state),
        .i_entry  (r_rd_data),
        .i_window (r_s1_window),
        .i_action (r_s1_action),
        .i_ctx_ok (r_s1_ok),
        .o_step   (step)
    );

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_action <= i_in.action;
            r_s1_ok     <= ctx_ok;
            r_s1_window <= i_in.stream_bits;
        end
        if (s1_adv) begin
            r_out <= step.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (s1_adv && step.state_we) begin
                r_state <= step.state;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

FILE: hdl/rad_step.sv
`default_nettype none

module rad_step
    import rad_pkg::*;
#(
    parameter int ANS_BITS       = 12,
    parameter int LOG_ENTRY_SIZE = 4
) (
    input  wire logic [31:0] i_state,
    input  wire t_entry      i_entry,
    input  wire logic [31:0] i_window,
    input  wire logic [1:0]  i_action,
    input  wire logic        i_ctx_ok,
    output t_step            o_step
);

    localparam logic [31:0] RES_MASK = (32'd1 << ANS_BITS) - 32'd1;

    logic [LOG_ENTRY_SIZE-1:0] pos;
    logic [31:0]               idx;
    logic                      right;
    logic [12:0]               freq;
    logic [12:0]               off;
    logic [31-ANS_BITS:0]      quot;
    logic [31:0]               dec;
    logic [31:0]               fill1;
    logic [31:0]               fill2;

    always_comb begin
        pos   = i_state[LOG_ENTRY_SIZE-1:0];
        idx   = (i_state & RES_MASK) >> LOG_ENTRY_SIZE;
        right = 32'(pos) >= 32'(i_entry.cutoff);
        freq  = i_entry.left_freq ^ (right ? i_entry.freq_xor : 13'd0);
        off   = (right ? 13'(i_entry.right_offset_base) : 13'd0) + 13'(pos);
        quot  = i_state[31:ANS_BITS];
        dec   = 32'(32'(freq) * 32'(quot)) + 32'(off);
        fill1 = {dec[15:0], i_window[31:16]};
        fill2 = {fill1[15:0], i_window[15:0]};
    end

    always_comb begin
        o_step = '0;
        case (i_action)
            ACT_LOAD_STATE: begin
                o_step.state_we          = 1'b1;
                o_step.state             = i_window;
                o_step.res.bits_consumed = USED_FULL;
            end
            ACT_DECODE: begin
                if (i_ctx_ok) begin
                    o_step.state_we   = 1'b1;
                    o_step.res.symbol = right ? i_entry.right_symbol : 8'(idx);
                    if (dec >= REFILL_LIMIT) begin
                        o_step.state             = dec;
                        o_step.res.bits_consumed = USED_NONE;
                    end else if (fill1 >= REFILL_LIMIT) begin
                        o_step.state             = fill1;
                        o_step.res.bits_consumed = USED_HALF;
                    end else begin
                        o_step.state             = fill2;
                        o_step.res.bits_consumed = USED_FULL;
                    end
                end
            end
            default: begin
                o_step = '0;
            end
        endcase
    end

endmodule

`default_nettype wire
